// ----- rtl/phase_accumulator_waveform_generator_macros.svh -----
// ----------------------------------------------------------------------------
// phase accumulator waveform generator assertion macros
// shared property forms for the block's checks
// ----------------------------------------------------------------------------
`ifndef PHASE_ACCUMULATOR_WAVEFORM_GENERATOR_MACROS_SVH
`define PHASE_ACCUMULATOR_WAVEFORM_GENERATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define PAWG_ASSERT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pawg assertion failed");

// next-cycle implication, disabled in reset
`define PAWG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pawg assertion failed");

`endif

// ----- rtl/pawg_pkg.sv -----
// ----------------------------------------------------------------------------
// pawg_pkg
// shared constants, codes, types and sine table functions
// ----------------------------------------------------------------------------
`default_nettype none

package pawg_pkg;

  localparam int PHASE_BITS_DEF     = 24;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int MAX_RUN_DEF        = 64;

  localparam int COUNT_W    = 7;
  localparam int STEP_W     = 24;
  localparam int WAVE_W     = 2;
  localparam int DUTY_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int Q30_FRAC = 30;
  localparam int MAG_W    = 31;
  localparam int AMP_PCT  = 33;

  localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
  localparam logic [DUTY_W-1:0] DUTY_RESET  = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_WAVEFORM   = 2'd1,
    CFG_DUTY       = 2'd2
  } cfg_idx_e;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAWTOOTH = 2'd3
  } wave_e;

  typedef struct packed {
    logic issue;
    logic last;
  } issue_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic neg;
  } stage_t;

  // q30 taylor series of sin(x) for x in [0, pi/2], clamped to [0, 1]
  function automatic logic [MAG_W-1:0] quarter_sine(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x) >> Q30_FRAC;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> Q30_FRAC) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> Q30_FRAC) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> Q30_FRAC) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> Q30_FRAC) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> Q30_FRAC) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> Q30_FRAC) / 64'd156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> Q30_FRAC) / 64'd210;
    sum  = sum - $signed(term);
    if (sum < 64'sd0) begin
      sum = 64'sd0;
    end
    if (sum > (64'sd1 <<< Q30_FRAC)) begin
      sum = 64'sd1 <<< Q30_FRAC;
    end
    return sum[MAG_W-1:0];
  endfunction

  // table entry for quarter-wave index q
  function automatic logic [MAG_W-1:0] sine_entry(input int q, input int addr_bits);
    logic [63:0] x;
    x = (64'(q) * HALF_PI_Q30) >> (addr_bits - 2);
    return quarter_sine(x);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pawg_req_if.sv -----
// ----------------------------------------------------------------------------
// pawg_req_if
// request channel carrying the frame count of one run
// ----------------------------------------------------------------------------
`default_nettype none

interface pawg_req_if;
  logic                         valid;
  logic                         ready;
  logic [pawg_pkg::COUNT_W-1:0] frame_count;

  modport source (output valid, output frame_count, input ready);
  modport sink (input valid, input frame_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/pawg_smp_if.sv -----
// ----------------------------------------------------------------------------
// pawg_smp_if
// sample channel carrying one waveform sample and its end-of-run mark
// ----------------------------------------------------------------------------
`default_nettype none

interface pawg_smp_if #(
  parameter int SAMPLE_BITS = pawg_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/pawg_cfg_if.sv -----
// ----------------------------------------------------------------------------
// pawg_cfg_if
// register write channel, index and data
// ----------------------------------------------------------------------------
`default_nettype none

interface pawg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pawg_pkg::CFG_IDX_W-1:0]  index;
  logic [pawg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/phase_accumulator_waveform_generator.sv -----
// ----------------------------------------------------------------------------
// phase_accumulator_waveform_generator
// phase-accumulator oscillator producing sine, square, triangle or sawtooth
//
// usage:
//   req_i takes one request holding a frame count; the block answers with
//   min(frame_count, MAX_RUN) samples on smp_o, the final one with last set.
//   a zero count yields nothing and leaves the phase alone.
//   cfg_i writes phase_step, waveform and duty; write only while idle.
//   a request loads the run counter; each sample passes the lookup register
//   and then the output register. throughput: one sample per cycle while
//   smp_o is not stalled, one sine table lookup per sample; a run holds
//   req_i off until its final sample has been issued.
//   a stalled smp_o holds the output register, then the lookup stage, then
//   stops the phase accumulator; no sample is lost or repeated.
//   reset clears the phase, the run counter and the registers to their
//   defaults (step 0, sine, duty one half).
// ----------------------------------------------------------------------------
`default_nettype none

`include "phase_accumulator_waveform_generator_macros.svh"

module phase_accumulator_waveform_generator #(
  parameter int PHASE_BITS     = pawg_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = pawg_pkg::SINE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS    = pawg_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_RUN        = pawg_pkg::MAX_RUN_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pawg_req_if.sink      req_i,
  pawg_smp_if.source    smp_o,
  pawg_cfg_if.sink      cfg_i
);

  logic [pawg_pkg::STEP_W-1:0] step_q;
  pawg_pkg::wave_e             wave_q;
  logic [pawg_pkg::DUTY_W-1:0] duty_q;

  pawg_pkg::issue_t           issue;
  pawg_pkg::stage_t           stage;
  logic [PHASE_BITS-1:0]      seq_phase;
  logic [PHASE_BITS-1:0]      lk_phase;
  logic [pawg_pkg::MAG_W-1:0] lk_mag;
  logic                       lk_free;
  logic                       out_free;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      wave_q <= pawg_pkg::WAVE_SINE;
      duty_q <= pawg_pkg::DUTY_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pawg_pkg::CFG_PHASE_STEP: step_q <= cfg_i.data[pawg_pkg::STEP_W-1:0];
        pawg_pkg::CFG_WAVEFORM:   wave_q <= pawg_pkg::wave_e'(cfg_i.data[pawg_pkg::WAVE_W-1:0]);
        pawg_pkg::CFG_DUTY:       duty_q <= cfg_i.data[pawg_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  pawg_seq #(
    .PHASE_BITS (PHASE_BITS),
    .MAX_RUN    (MAX_RUN)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .frame_count_i (req_i.frame_count),
    .req_ready_o   (req_i.ready),
    .step_i        (PHASE_BITS'(step_q)),
    .free_i        (lk_free),
    .issue_o       (issue),
    .phase_o       (seq_phase)
  );

  pawg_lookup #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_lookup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .issue_i    (issue),
    .phase_i    (seq_phase),
    .out_free_i (out_free),
    .free_o     (lk_free),
    .stage_o    (stage),
    .phase_o    (lk_phase),
    .mag_o      (lk_mag)
  );

  pawg_shape #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_shape (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .phase_i     (lk_phase),
    .mag_i       (lk_mag),
    .waveform_i  (wave_q),
    .duty_i      (duty_q),
    .out_ready_i (smp_o.ready),
    .out_valid_o (smp_o.valid),
    .sample_o    (smp_o.sample),
    .last_o      (smp_o.last),
    .free_o      (out_free)
  );

  // a sample enters the lookup stage only when that stage can take it
  `PAWG_ASSERT(a_issue_room, clk_i, rst_ni, issue.issue, lk_free)

  // a request with a nonzero count keeps the request side closed
  `PAWG_ASSERT_NEXT(a_req_busy, clk_i, rst_ni, req_i.valid && req_i.ready && req_i.frame_count != '0, !req_i.ready)

  // issuing the final sample of a run frees the request side
  `PAWG_ASSERT_NEXT(a_run_done, clk_i, rst_ni, issue.issue && issue.last, req_i.ready)

endmodule

`default_nettype wire

// ----- rtl/pawg_seq.sv -----
// ----------------------------------------------------------------------------
// pawg_seq
// run counter and phase accumulator, issues one sample per free slot
// ----------------------------------------------------------------------------
`default_nettype none

module pawg_seq #(
  parameter int PHASE_BITS = pawg_pkg::PHASE_BITS_DEF,
  parameter int MAX_RUN    = pawg_pkg::MAX_RUN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  logic [pawg_pkg::COUNT_W-1:0] frame_count_i,
  output logic                         req_ready_o,
  input  logic [PHASE_BITS-1:0]        step_i,
  input  logic                         free_i,
  output pawg_pkg::issue_t             issue_o,
  output logic [PHASE_BITS-1:0]        phase_o
);

  localparam int RUN_W = $clog2(MAX_RUN + 1);

  logic [RUN_W-1:0]             remain_q, remain_d;
  logic [PHASE_BITS-1:0]        phase_q, phase_d;
  logic [RUN_W-1:0]             run_len;
  logic [pawg_pkg::COUNT_W-1:0] max_run;
  logic                         req_acc;

  assign max_run = pawg_pkg::COUNT_W'(MAX_RUN);
  assign run_len = (frame_count_i > max_run) ? RUN_W'(MAX_RUN) : RUN_W'(frame_count_i);

  assign req_ready_o   = (remain_q == '0);
  assign req_acc       = req_valid_i && req_ready_o;
  assign issue_o.issue = (remain_q != '0) && free_i;
  assign issue_o.last  = (remain_q == RUN_W'(1));
  assign phase_o       = phase_q;

  always_comb begin
    remain_d = remain_q;
    phase_d  = phase_q;
    if (req_acc) begin
      remain_d = run_len;
    end else if (issue_o.issue) begin
      remain_d = remain_q - RUN_W'(1);
    end
    if (issue_o.issue) begin
      phase_d = phase_q + step_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
      phase_q  <= '0;
    end else begin
      remain_q <= remain_d;
      phase_q  <= phase_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pawg_lookup.sv -----
// ----------------------------------------------------------------------------
// pawg_lookup
// quarter-wave sine table with registered read and the lookup stage
// ----------------------------------------------------------------------------
`default_nettype none

module pawg_lookup #(
  parameter int PHASE_BITS     = pawg_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = pawg_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pawg_pkg::issue_t           issue_i,
  input  logic [PHASE_BITS-1:0]      phase_i,
  input  logic                       out_free_i,
  output logic                       free_o,
  output pawg_pkg::stage_t           stage_o,
  output logic [PHASE_BITS-1:0]      phase_o,
  output logic [pawg_pkg::MAG_W-1:0] mag_o
);

  localparam int QW    = SINE_ADDR_BITS - 2;
  localparam int QSIZE = 1 << QW;
  localparam int IDX_W = QW + 1;

  logic [SINE_ADDR_BITS-1:0]  addr;
  logic [1:0]                 quad;
  logic [IDX_W-1:0]           idx;
  logic [pawg_pkg::MAG_W-1:0] rom [QSIZE+1];

  logic                       valid_q, valid_d;
  logic                       last_q;
  logic                       neg_q;
  logic [PHASE_BITS-1:0]      phase_q;
  logic [pawg_pkg::MAG_W-1:0] mag_q;

  if (PHASE_BITS >= SINE_ADDR_BITS) begin : g_addr_hi
    assign addr = phase_i[PHASE_BITS-1 -: SINE_ADDR_BITS];
  end else begin : g_addr_lo
    assign addr = {phase_i, {(SINE_ADDR_BITS - PHASE_BITS){1'b0}}};
  end

  assign quad = addr[SINE_ADDR_BITS-1 -: 2];
  assign idx  = quad[0] ? (IDX_W'(QSIZE) - {1'b0, addr[QW-1:0]}) : {1'b0, addr[QW-1:0]};

  for (genvar g = 0; g <= QSIZE; g++) begin : g_rom
    assign rom[g] = pawg_pkg::sine_entry(g, SINE_ADDR_BITS);
  end

  assign free_o        = !valid_q || out_free_i;
  assign valid_d       = issue_i.issue ? 1'b1 : (out_free_i ? 1'b0 : valid_q);
  assign stage_o.valid = valid_q;
  assign stage_o.last  = last_q;
  assign stage_o.neg   = neg_q;
  assign phase_o       = phase_q;
  assign mag_o         = mag_q;

  always_ff @(posedge clk_i) begin
    if (issue_i.issue) begin
      mag_q   <= rom[idx];
      last_q  <= issue_i.last;
      neg_q   <= quad[1];
      phase_q <= phase_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pawg_shape.sv -----
// ----------------------------------------------------------------------------
// pawg_shape
// waveform shaping and output register
// ----------------------------------------------------------------------------
`default_nettype none

module pawg_shape #(
  parameter int PHASE_BITS  = pawg_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = pawg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pawg_pkg::stage_t              stage_i,
  input  logic [PHASE_BITS-1:0]         phase_i,
  input  logic [pawg_pkg::MAG_W-1:0]    mag_i,
  input  pawg_pkg::wave_e               waveform_i,
  input  logic [pawg_pkg::DUTY_W-1:0]   duty_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                          last_o,
  output logic                          free_o
);

  localparam int ONE  = 1 << (SAMPLE_BITS - 1);
  localparam int HI   = ONE - 1;
  localparam int AMP  = (pawg_pkg::AMP_PCT * ONE + 50) / 100;
  localparam int TW   = PHASE_BITS + SAMPLE_BITS + 2;
  localparam int SW   = PHASE_BITS + SAMPLE_BITS;
  localparam int VW   = SAMPLE_BITS + 3;
  localparam int RBIT = pawg_pkg::Q30_FRAC - SAMPLE_BITS;

  localparam logic signed [VW-1:0] ONE_T = VW'(ONE);
  localparam logic signed [VW-1:0] TWO_T = VW'(2 * ONE);
  localparam logic signed [VW-1:0] HI_T  = VW'(HI);

  logic [pawg_pkg::MAG_W:0]    rsum;
  logic [SAMPLE_BITS-1:0]      sin_m;
  logic [SAMPLE_BITS-1:0]      sin_v;
  logic signed [31:0]          sq_s;
  logic signed [17:0]          thr_hi;
  logic signed [31:0]          thr;
  logic [SAMPLE_BITS-1:0]      sq_v;
  logic [TW-1:0]               tria_num;
  logic signed [VW-1:0]        tria_t;
  logic [SW-1:0]               saw_num;
  logic signed [SAMPLE_BITS:0] saw_t;
  logic [SAMPLE_BITS-1:0]      shaped;

  logic                        valid_q;
  logic [SAMPLE_BITS-1:0]      sample_q;
  logic                        last_q;

  always_comb begin
    // sine, rounded half up then held below full scale
    rsum  = {1'b0, mag_i} + (pawg_pkg::MAG_W + 1)'(1 << RBIT);
    sin_m = rsum[RBIT+1 +: SAMPLE_BITS];
    if (sin_m > SAMPLE_BITS'(HI)) begin
      sin_m = SAMPLE_BITS'(HI);
    end
    sin_v = stage_i.neg ? (-sin_m) : sin_m;

    // square, q30 sine against 1 - 2 * duty
    sq_s = $signed({1'b0, mag_i});
    if (stage_i.neg) begin
      sq_s = -sq_s;
    end
    thr_hi = 18'sd65536 - $signed({1'b0, duty_i, 1'b0});
    thr    = $signed({thr_hi, 14'b0});
    sq_v   = (sq_s < thr) ? (-SAMPLE_BITS'(AMP)) : SAMPLE_BITS'(AMP);

    // triangle, 4p - 1 folded at full scale
    tria_num = {1'b0, phase_i, {(SAMPLE_BITS + 1){1'b0}}} + (TW'(1) << (PHASE_BITS - 1));
    tria_t   = $signed({1'b0, tria_num[PHASE_BITS +: SAMPLE_BITS + 2]}) - ONE_T;
    if (tria_t > ONE_T) begin
      tria_t = TWO_T - tria_t;
    end
    if (tria_t > HI_T) begin
      tria_t = HI_T;
    end

    // sawtooth, p - 1/2
    saw_num = {1'b0, phase_i, {(SAMPLE_BITS - 1){1'b0}}} + (SW'(1) << (PHASE_BITS - 1));
    saw_t   = $signed({1'b0, saw_num[PHASE_BITS +: SAMPLE_BITS]}) - (SAMPLE_BITS + 1)'(ONE / 2);

    case (waveform_i)
      pawg_pkg::WAVE_SINE:     shaped = sin_v;
      pawg_pkg::WAVE_SQUARE:   shaped = sq_v;
      pawg_pkg::WAVE_TRIANGLE: shaped = tria_t[SAMPLE_BITS-1:0];
      pawg_pkg::WAVE_SAWTOOTH: shaped = saw_t[SAMPLE_BITS-1:0];
      default:                 shaped = sin_v;
    endcase
  end

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign sample_o    = $signed(sample_q);
  assign last_o      = last_q;

  always_ff @(posedge clk_i) begin
    if (free_o && stage_i.valid) begin
      sample_q <= shaped;
      last_q   <= stage_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= stage_i.valid;
    end
  end

endmodule

`default_nettype wire

// ----- test/tb_phase_accumulator_waveform_generator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_phase_accumulator_waveform_generator
// checks every sample and end-of-run mark of the oscillator against its own
// phase accumulator and waveform predictor, under bursty requests, random
// output stalls, one long output hold and register changes between phases
// ----------------------------------------------------------------------------

module tb_phase_accumulator_waveform_generator;

  localparam logic [1:0]  CFG_RESERVED  = 2'd3;
  localparam int          RUN_MAX       = 64;
  localparam int          RAND_PHASES   = 8;
  localparam int          RAND_ITEMS    = 25;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          TAIL_CYCLES   = 20;
  localparam int          HOLD_AFTER    = 1500;
  localparam int          HOLD_CYCLES   = 300;
  localparam logic [63:0] PI_HALF_Q30   = 64'd1686629713;
  localparam longint      SQUARE_AMP    = (33 * 32768 + 50) / 100;

  class sample_scoreboard;
    typedef struct packed {
      logic signed [15:0] sample;
      logic               last;
    } run_sample_t;

    bit [23:0]       step;
    pawg_pkg::wave_e wave;
    bit [15:0]       duty;
    bit [23:0]       phase;
    run_sample_t     pending_samples[$];
    int              errors;

    function new();
      step   = '0;
      wave   = pawg_pkg::WAVE_SINE;
      duty   = pawg_pkg::DUTY_RESET;
      phase  = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        pawg_pkg::CFG_PHASE_STEP: step = data;
        pawg_pkg::CFG_WAVEFORM:   wave = pawg_pkg::wave_e'(data[1:0]);
        pawg_pkg::CFG_DUTY:       duty = data[15:0];
        default: ;
      endcase
    endfunction

    // signed q30 sine at the table address of the current phase
    function longint sine_q30();
      bit [9:0]  addr;
      bit [63:0] q;
      bit [63:0] x;
      bit [63:0] x2;
      bit [63:0] term;
      longint    acc;
      int        n;
      addr = phase[23:14];
      q    = 64'(addr[7:0]);
      if (addr[8]) begin
        q = 64'd256 - q;
      end
      x    = (q * PI_HALF_Q30) >> 8;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      if (acc > (64'sd1 <<< 30)) begin
        acc = 64'sd1 <<< 30;
      end
      return addr[9] ? -acc : acc;
    endfunction

    // phase fraction times 2^shift, rounded half up
    function longint rounded_phase(int shift);
      bit [63:0] num;
      num = 64'(phase) << shift;
      return longint'((num + 64'h80_0000) >> 24);
    endfunction

    function logic signed [15:0] predict_sample();
      longint s;
      longint m;
      longint v;
      longint thr;
      case (wave)
        pawg_pkg::WAVE_SQUARE: begin
          thr = (65536 - 2 * longint'(duty)) * 16384;
          v   = (sine_q30() < thr) ? -SQUARE_AMP : SQUARE_AMP;
        end
        pawg_pkg::WAVE_TRIANGLE: begin
          v = rounded_phase(17) - 32768;
          if (v > 32768) begin
            v = 65536 - v;
          end
        end
        pawg_pkg::WAVE_SAWTOOTH: v = rounded_phase(15) - 16384;
        default: begin
          s = sine_q30();
          m = (s < 0) ? -s : s;
          m = (m + 16384) >> 15;
          if (m > 32767) begin
            m = 32767;
          end
          v = (s < 0) ? -m : m;
        end
      endcase
      if (v > 32767) begin
        v = 32767;
      end
      if (v < -32768) begin
        v = -32768;
      end
      return 16'(v);
    endfunction

    function void note_request(logic [6:0] frame_count);
      int          n;
      int          k;
      run_sample_t r;
      n = (frame_count > RUN_MAX) ? RUN_MAX : int'(frame_count);
      for (k = 0; k < n; k++) begin
        r.sample = predict_sample();
        r.last   = (k == n - 1);
        pending_samples.push_back(r);
        phase = phase + step;
      end
    endfunction

    function void check_sample(logic signed [15:0] sample, logic last);
      run_sample_t r;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual %0d last %0b",
                 $time, sample, last);
        errors++;
        return;
      end
      r = pending_samples.pop_front();
      if (sample !== r.sample) begin
        $display("%0t: sample mismatch, expected %0d, actual %0d", $time, r.sample, sample);
        errors++;
      end
      if (last !== r.last) begin
        $display("%0t: last mismatch, expected %0b, actual %0b", $time, r.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pawg_req_if req ();
  pawg_smp_if #(.SAMPLE_BITS(pawg_pkg::SAMPLE_BITS_DEF)) smp ();
  pawg_cfg_if cfg ();

  sample_scoreboard sb = new();
  int samples_seen = 0;
  int burst_left = 0;

  phase_accumulator_waveform_generator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .smp_o  (smp),
    .cfg_i  (cfg)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && smp.valid && smp.ready) begin
      sb.check_sample(smp.sample, smp.last);
      samples_seen++;
    end
  end

  // output stall patterns, with one long hold once traffic is under way
  initial begin : rx_pattern
    int  mode;
    int  span;
    int  k;
    bit  held;
    held      = 1'b0;
    smp.ready = 1'b0;
    wait (rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      for (k = 0; k < span; k++) begin
        @(negedge clk_i);
        if (!held && samples_seen >= HOLD_AFTER) begin
          smp.ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          held = 1'b1;
        end
        case (mode)
          0: smp.ready = 1'b1;
          1: smp.ready = 1'($urandom_range(0, 1));
          2: smp.ready = (k % 4) != 3;
          default: smp.ready = (k % 7) < 2;
        endcase
      end
    end
  end

  task automatic pace_sender();
    if (burst_left == 0) begin
      req.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
  endtask

  task automatic send_request(input logic [6:0] frame_count);
    pace_sender();
    req.valid       = 1'b1;
    req.frame_count = frame_count;
    do @(posedge clk_i); while (!req.ready);
    sb.note_request(frame_count);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = data;
    do @(posedge clk_i); while (!cfg.ready);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  task automatic wait_drain(input int settle);
    req.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  function automatic logic [6:0] pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return 7'($urandom_range(RUN_MAX + 1, 127));
    if (r < 4)  return 7'(RUN_MAX);
    if (r < 6)  return 7'd1;
    return 7'($urandom_range(1, RUN_MAX));
  endfunction

  function automatic logic [23:0] pick_step();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return 24'hFF_FFFF;
    if (r < 5)  return 24'($urandom_range(1, 24'h0F_FFFF));
    return 24'($urandom);
  endfunction

  function automatic logic [15:0] pick_duty();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return '0;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  initial begin : stimulus
    int phase_idx;
    int i;
    rst_ni          = 1'b0;
    req.valid       = 1'b0;
    req.frame_count = '0;
    cfg.valid       = 1'b0;
    cfg.index       = '0;
    cfg.data        = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // register defaults, zero step, zero count
    send_request(7'd1);
    send_request(7'd0);
    send_request(7'd2);
    wait_drain(SETTLE_CYCLES);

    // one full period in 64 samples
    write_reg(pawg_pkg::CFG_PHASE_STEP, 24'h04_0000);
    send_request(7'd64);
    wait_drain(SETTLE_CYCLES);

    write_reg(pawg_pkg::CFG_WAVEFORM, 24'(pawg_pkg::WAVE_SQUARE));
    write_reg(pawg_pkg::CFG_DUTY, 24'h00_0000);
    send_request(7'd64);
    wait_drain(SETTLE_CYCLES);
    write_reg(pawg_pkg::CFG_DUTY, 24'h00_FFFF);
    send_request(7'd64);
    wait_drain(SETTLE_CYCLES);
    write_reg(pawg_pkg::CFG_DUTY, 24'hFF_8000);
    send_request(7'd32);
    wait_drain(SETTLE_CYCLES);

    write_reg(pawg_pkg::CFG_WAVEFORM, 24'(pawg_pkg::WAVE_TRIANGLE));
    send_request(7'd64);
    wait_drain(SETTLE_CYCLES);
    write_reg(pawg_pkg::CFG_WAVEFORM, {22'h3F_FFFF, pawg_pkg::WAVE_SAWTOOTH});
    send_request(7'd127);
    send_request(7'd65);
    wait_drain(SETTLE_CYCLES);

    // widest step, ignored index, half-period step
    write_reg(pawg_pkg::CFG_PHASE_STEP, 24'hFF_FFFF);
    write_reg(pawg_pkg::CFG_WAVEFORM, 24'(pawg_pkg::WAVE_SINE));
    send_request(7'd5);
    wait_drain(SETTLE_CYCLES);
    write_reg(CFG_RESERVED, 24'hFF_FFFF);
    send_request(7'd3);
    wait_drain(SETTLE_CYCLES);
    write_reg(pawg_pkg::CFG_PHASE_STEP, 24'h80_0000);
    send_request(7'd4);
    wait_drain(SETTLE_CYCLES);
    write_reg(pawg_pkg::CFG_WAVEFORM, 24'(pawg_pkg::WAVE_TRIANGLE));
    send_request(7'd4);
    wait_drain(SETTLE_CYCLES);

    for (phase_idx = 0; phase_idx < RAND_PHASES; phase_idx++) begin
      write_reg(pawg_pkg::CFG_PHASE_STEP, pick_step());
      write_reg(pawg_pkg::CFG_WAVEFORM, {22'($urandom), 2'(phase_idx)});
      write_reg(pawg_pkg::CFG_DUTY, {8'($urandom), pick_duty()});
      for (i = 0; i < RAND_ITEMS; i++) begin
        send_request(pick_count());
      end
      wait_drain(SETTLE_CYCLES);
    end

    wait_drain(TAIL_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- phase_accumulator_waveform_generator.f -----
+incdir+rtl
rtl/pawg_pkg.sv
rtl/pawg_req_if.sv
rtl/pawg_smp_if.sv
rtl/pawg_cfg_if.sv
rtl/pawg_seq.sv
rtl/pawg_lookup.sv
rtl/pawg_shape.sv
rtl/phase_accumulator_waveform_generator.sv
test/tb_phase_accumulator_waveform_generator.sv
